/* hdl/per_source_token_bucket_limiter_defines.svh */
// Assertion macros shared by the rate limiter RTL.
`ifndef PER_SOURCE_TOKEN_BUCKET_LIMITER_DEFINES_SVH
`define PER_SOURCE_TOKEN_BUCKET_LIMITER_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define PSTBL_ASSERT_NOW(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// The condition must hold in the cycle after the trigger.
`define PSTBL_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

/* hdl/pstbl_pkg.sv */
// Types and constants shared by the rate limiter modules.
package pstbl_pkg;

	localparam int DATA_W    = 64;
	localparam int TOKEN_W   = 30;
	localparam int IDLE_W    = 32;
	localparam int LIMIT_W   = 11;
	localparam int NET_W     = 32;
	localparam int REMOVED_W = 11;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 32;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_PACKET_COST = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOKEN_MAX   = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_LIMIT  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_LIMIT = 4'd3;

	// Reset values: 1e9 / 20 packets per second, burst of 5, one second idle.
	localparam logic [TOKEN_W-1:0] PACKET_COST_RST = 30'd50000000;
	localparam logic [TOKEN_W-1:0] TOKEN_MAX_RST   = 30'd250000000;
	localparam logic [IDLE_W-1:0]  IDLE_LIMIT_RST  = 32'd1000000000;
	localparam logic [LIMIT_W-1:0] ENTRY_LIMIT_RST = 11'd1024;

	// Operation and protocol codes.
	localparam logic OP_SWEEP = 1'b1;
	localparam logic [1:0] KIND_IPV4 = 2'd0;

	// Result outcome codes.
	localparam logic [2:0] OUT_HIT_OK   = 3'd0;
	localparam logic [2:0] OUT_HIT_DENY = 3'd1;
	localparam logic [2:0] OUT_NEW_OK   = 3'd2;
	localparam logic [2:0] OUT_FULL     = 3'd3;
	localparam logic [2:0] OUT_BAD_PROTO = 3'd4;
	localparam logic [2:0] OUT_SWEPT    = 3'd5;

	// One table slot as stored in the entry memory.
	typedef struct packed {
		logic               valid;
		logic               family;
		logic [DATA_W-1:0]  addr;
		logic [NET_W-1:0]   net;
		logic [DATA_W-1:0]  last_time;
		logic [TOKEN_W-1:0] tokens;
	} pstbl_entry_t;

	// Request to the shared add/subtract unit.
	typedef struct packed {
		logic              sub;
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
	} pstbl_alu_req_t;

	// Answer of the shared unit; ge is a >= b for a subtraction.
	typedef struct packed {
		logic [DATA_W-1:0] res;
		logic              ge;
	} pstbl_alu_rsp_t;

endpackage

/* hdl/pstbl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pstbl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hdl/pstbl_alu.sv */
// Shared 64-bit add/subtract unit with an unsigned compare flag.
module pstbl_alu (
	input  pstbl_pkg::pstbl_alu_req_t req,
	output pstbl_pkg::pstbl_alu_rsp_t rsp
);

	logic [pstbl_pkg::DATA_W:0] sum;

	// A subtraction adds the inverted operand plus one; the carry out is a >= b.
	always_comb begin
		if (req.sub) begin
			sum = {1'b0, req.a} + {1'b0, ~req.b} + {{pstbl_pkg::DATA_W{1'b0}}, 1'b1};
		end else begin
			sum = {1'b0, req.a} + {1'b0, req.b};
		end
		rsp.res = sum[pstbl_pkg::DATA_W-1:0];
		rsp.ge  = sum[pstbl_pkg::DATA_W];
	end

endmodule

/* hdl/per_source_token_bucket_limiter.sv */
// Top level of the per-source token bucket rate limiter: sequencer, table and registers.
// A packet beat scans the slots in turn, a read and a compare state per slot, via the single
// read port of the entry memory; a hit ends the scan early. A sweep beat also passes the two
// sweep steps on an occupied slot. A bad protocol goes straight to the result. One beat is
// worked on at a time; the result register lets the next beat enter meanwhile. Reset clears
// control state, then a clearing pass writes every slot once to empty the table.
module per_source_token_bucket_limiter #(
	parameter int TABLE_ENTRIES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port.
	input  logic        cfg_we,
	input  logic [3:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// Input channel.
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [1:0]  protocol_kind,
	input  logic [63:0] source_addr,
	input  logic [31:0] net_id,
	input  logic [63:0] now_ns,
	// Output channel.
	output logic        out_valid,
	input  logic        out_stall,
	output logic        allowed,
	output logic [2:0]  outcome,
	output logic [10:0] removed_count
);

	`include "per_source_token_bucket_limiter_defines.svh"

	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam int RW = pstbl_pkg::REMOVED_W;
	localparam int DW = pstbl_pkg::DATA_W;
	localparam int TW = pstbl_pkg::TOKEN_W;
	localparam int EW = $bits(pstbl_pkg::pstbl_entry_t);
	localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);

	// Sequencer states.
	localparam logic [3:0] S_CLEAR = 4'd0;  // reset clearing pass over the table
	localparam logic [3:0] S_IDLE  = 4'd1;  // waiting for an input beat
	localparam logic [3:0] S_RD    = 4'd2;  // read address of the current slot issued
	localparam logic [3:0] S_CHK   = 4'd3;  // slot data available, key compare
	localparam logic [3:0] S_SW1   = 4'd4;  // sweep: idle time of the slot
	localparam logic [3:0] S_SW2   = 4'd5;  // sweep: compare with the idle limit
	localparam logic [3:0] S_SWEND = 4'd6;  // sweep: lower the entry count
	localparam logic [3:0] S_H1    = 4'd7;  // hit: elapsed time
	localparam logic [3:0] S_H2    = 4'd8;  // hit: room left below the cap
	localparam logic [3:0] S_H3    = 4'd9;  // hit: elapsed against room
	localparam logic [3:0] S_H4    = 4'd10; // hit: add elapsed time
	localparam logic [3:0] S_H5    = 4'd11; // hit: spend packet cost, write back
	localparam logic [3:0] S_MISS  = 4'd12; // miss: entry limit check
	localparam logic [3:0] S_NEW   = 4'd13; // miss: create the entry
	localparam logic [3:0] S_DONE  = 4'd14; // result ready for the output register

	logic [3:0] state_q;
	logic [AW-1:0] idx_q;
	logic [AW-1:0] free_idx_q;
	logic free_found_q;
	logic sweep_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] removed_q;

	// Configuration registers.
	logic [TW-1:0] packet_cost_q;
	logic [TW-1:0] token_max_q;
	logic [pstbl_pkg::IDLE_W-1:0] idle_limit_q;
	logic [pstbl_pkg::LIMIT_W-1:0] entry_limit_q;

	// Captured beat and per-slot working values.
	logic family_q;
	logic [DW-1:0] addr_q;
	logic [pstbl_pkg::NET_W-1:0] net_q;
	logic [DW-1:0] now_q;
	pstbl_pkg::pstbl_entry_t e_q;
	logic [DW-1:0] elapsed_q;
	logic [DW-1:0] room_q;
	logic cap_q;
	logic [TW-1:0] tok_q;
	logic res_allowed_q;
	logic [2:0] res_outcome_q;

	// Output register.
	logic out_valid_q;
	logic allowed_q;
	logic [2:0] outcome_q;
	logic [RW-1:0] removed_out_q;

	// Entry memory ports.
	logic ram_we;
	logic [AW-1:0] ram_waddr;
	pstbl_pkg::pstbl_entry_t ram_wdata;
	pstbl_pkg::pstbl_entry_t rd_entry;
	logic [EW-1:0] ram_rdata;

	pstbl_pkg::pstbl_alu_req_t alu_req;
	pstbl_pkg::pstbl_alu_rsp_t alu_rsp;

	logic key_match;
	logic slot_last;
	logic stale;
	logic out_load;
	logic [TW-1:0] tok_spent;

	assign rd_entry = pstbl_pkg::pstbl_entry_t'(ram_rdata);

	pstbl_ram #(
		.WIDTH(EW),
		.DEPTH(TABLE_ENTRIES)
	) u_entry_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	pstbl_alu u_alu (
		.req(alu_req),
		.rsp(alu_rsp)
	);

	// Only one beat is in flight; the next is taken once the sequencer is back in idle.
	assign in_stall = (state_q != S_IDLE);

	assign key_match = rd_entry.valid && (rd_entry.family == family_q) &&
		(rd_entry.addr == addr_q) && (rd_entry.net == net_q);
	assign slot_last = (idx_q == LAST_IDX);
	// In the second sweep step the unit computes idle_limit - elapsed; a borrow means stale.
	assign stale = !alu_rsp.ge;
	assign tok_spent = alu_rsp.ge ? alu_rsp.res[TW-1:0] : tok_q;
	// A finished result enters the output register when it is empty or being drained.
	assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	// Operand selection for the shared add/subtract unit.
	always_comb begin
		alu_req.sub = 1'b1;
		alu_req.a = '0;
		alu_req.b = '0;
		unique case (state_q)
			S_SW1, S_H1: begin
				alu_req.a = now_q;
				alu_req.b = e_q.last_time;
			end
			S_SW2: begin
				alu_req.a = DW'(idle_limit_q);
				alu_req.b = elapsed_q;
			end
			S_SWEND: begin
				alu_req.a = DW'(count_q);
				alu_req.b = DW'(removed_q);
			end
			S_H2: begin
				alu_req.a = DW'(token_max_q);
				alu_req.b = DW'(e_q.tokens);
			end
			S_H3: begin
				alu_req.a = elapsed_q;
				alu_req.b = room_q;
			end
			S_H4: begin
				alu_req.sub = 1'b0;
				alu_req.a = DW'(e_q.tokens);
				alu_req.b = elapsed_q;
			end
			S_H5: begin
				alu_req.a = DW'(tok_q);
				alu_req.b = DW'(packet_cost_q);
			end
			S_MISS: begin
				alu_req.a = DW'(count_q);
				alu_req.b = DW'(entry_limit_q);
			end
			S_NEW: begin
				alu_req.a = DW'(token_max_q);
				alu_req.b = DW'(packet_cost_q);
			end
			default: begin
			end
		endcase
	end

	// Entry memory write port: clearing pass, sweep removal, hit update, new entry.
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = '0;
		unique case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
			end
			S_SW2: begin
				ram_we = stale;
				ram_wdata = e_q;
				ram_wdata.valid = 1'b0;
			end
			S_H5: begin
				ram_we = 1'b1;
				ram_wdata = e_q;
				ram_wdata.last_time = now_q;
				ram_wdata.tokens = tok_spent;
			end
			S_NEW: begin
				ram_we = 1'b1;
				ram_waddr = free_idx_q;
				ram_wdata.valid = 1'b1;
				ram_wdata.family = family_q;
				ram_wdata.addr = addr_q;
				ram_wdata.net = net_q;
				ram_wdata.last_time = now_q;
				ram_wdata.tokens = alu_rsp.ge ? alu_rsp.res[TW-1:0] : '0;
			end
			default: begin
			end
		endcase
	end

	// Sequencer, counters and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			idx_q <= '0;
			free_idx_q <= '0;
			free_found_q <= 1'b0;
			sweep_q <= 1'b0;
			count_q <= '0;
			removed_q <= '0;
			out_valid_q <= 1'b0;
			packet_cost_q <= pstbl_pkg::PACKET_COST_RST;
			token_max_q <= pstbl_pkg::TOKEN_MAX_RST;
			idle_limit_q <= pstbl_pkg::IDLE_LIMIT_RST;
			entry_limit_q <= pstbl_pkg::ENTRY_LIMIT_RST;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					pstbl_pkg::REG_PACKET_COST: packet_cost_q <= cfg_data[TW-1:0];
					pstbl_pkg::REG_TOKEN_MAX: token_max_q <= cfg_data[TW-1:0];
					pstbl_pkg::REG_IDLE_LIMIT: idle_limit_q <= cfg_data;
					pstbl_pkg::REG_ENTRY_LIMIT:
						entry_limit_q <= cfg_data[pstbl_pkg::LIMIT_W-1:0];
					default: begin
					end
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_CLEAR: begin
					if (slot_last) begin
						idx_q <= '0;
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + AW'(1);
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						idx_q <= '0;
						free_found_q <= 1'b0;
						removed_q <= '0;
						sweep_q <= (operation == pstbl_pkg::OP_SWEEP);
						if (operation != pstbl_pkg::OP_SWEEP && protocol_kind[1]) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (sweep_q) begin
						if (rd_entry.valid) begin
							state_q <= S_SW1;
						end else if (slot_last) begin
							state_q <= S_SWEND;
						end else begin
							idx_q <= idx_q + AW'(1);
							state_q <= S_RD;
						end
					end else begin
						if (!rd_entry.valid && !free_found_q) begin
							free_found_q <= 1'b1;
							free_idx_q <= idx_q;
						end
						if (key_match) begin
							state_q <= S_H1;
						end else if (slot_last) begin
							state_q <= S_MISS;
						end else begin
							idx_q <= idx_q + AW'(1);
							state_q <= S_RD;
						end
					end
				end
				S_SW1: begin
					state_q <= S_SW2;
				end
				S_SW2: begin
					if (stale) begin
						removed_q <= removed_q + CW'(1);
					end
					if (slot_last) begin
						state_q <= S_SWEND;
					end else begin
						idx_q <= idx_q + AW'(1);
						state_q <= S_RD;
					end
				end
				S_SWEND: begin
					count_q <= alu_rsp.ge ? alu_rsp.res[CW-1:0] : '0;
					state_q <= S_DONE;
				end
				S_H1: begin
					state_q <= S_H2;
				end
				S_H2: begin
					state_q <= S_H3;
				end
				S_H3: begin
					state_q <= (cap_q || alu_rsp.ge) ? S_H5 : S_H4;
				end
				S_H4: begin
					state_q <= S_H5;
				end
				S_H5: begin
					state_q <= S_DONE;
				end
				S_MISS: begin
					state_q <= (alu_rsp.ge || !free_found_q) ? S_DONE : S_NEW;
				end
				S_NEW: begin
					count_q <= count_q + CW'(1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers: captured beat, slot copy, bucket arithmetic, result.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					family_q <= protocol_kind[0];
					net_q <= net_id;
					now_q <= now_ns;
					// An IPv4 key is the low 32 bits of the address.
					if (protocol_kind == pstbl_pkg::KIND_IPV4) begin
						addr_q <= {32'd0, source_addr[31:0]};
					end else begin
						addr_q <= source_addr;
					end
					res_allowed_q <= 1'b0;
					res_outcome_q <= pstbl_pkg::OUT_BAD_PROTO;
				end
			end
			S_CHK: begin
				e_q <= rd_entry;
			end
			S_SW1, S_H1: begin
				// Time running backwards counts as no time at all.
				elapsed_q <= alu_rsp.ge ? alu_rsp.res : '0;
			end
			S_H2: begin
				room_q <= alu_rsp.res;
				cap_q <= !alu_rsp.ge || (alu_rsp.res == '0);
			end
			S_H3: begin
				tok_q <= token_max_q;
			end
			S_H4: begin
				tok_q <= alu_rsp.res[TW-1:0];
			end
			S_H5: begin
				res_allowed_q <= alu_rsp.ge;
				res_outcome_q <= alu_rsp.ge ? pstbl_pkg::OUT_HIT_OK : pstbl_pkg::OUT_HIT_DENY;
			end
			S_SWEND: begin
				res_allowed_q <= 1'b0;
				res_outcome_q <= pstbl_pkg::OUT_SWEPT;
			end
			S_MISS: begin
				res_allowed_q <= 1'b0;
				res_outcome_q <= pstbl_pkg::OUT_FULL;
			end
			S_NEW: begin
				res_allowed_q <= 1'b1;
				res_outcome_q <= pstbl_pkg::OUT_NEW_OK;
			end
			default: begin
			end
		endcase

		if (out_load) begin
			allowed_q <= res_allowed_q;
			outcome_q <= res_outcome_q;
			removed_out_q <= RW'(removed_q);
		end
	end

	assign out_valid = out_valid_q;
	assign allowed = allowed_q;
	assign outcome = outcome_q;
	assign removed_count = removed_out_q;

	// The entry count can never pass the table size.
	`PSTBL_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(TABLE_ENTRIES), "entry count exceeds table")
	// A sweep never removes more entries than the entry count holds.
	`PSTBL_ASSERT_NOW(a_sweep_bound, state_q == S_SWEND, removed_q <= count_q, "sweep removed too many")
	// Creating an entry raises the count by exactly one.
	`PSTBL_ASSERT_NEXT(a_new_count, state_q == S_NEW, count_q == $past(count_q) + CW'(1), "count not bumped")

endmodule
